### rtl/hkrb_pkg.sv
// Shared types, constants and codes for the HID key report builder.
package hkrb_pkg;

    localparam int TRACK_DEPTH = 16;
    localparam int CAPACITY    = TRACK_DEPTH - 2;
    localparam int IDX_W       = $clog2(TRACK_DEPTH);
    localparam int KEY_SLOTS   = 6;
    localparam int SLOT_W      = $clog2(KEY_SLOTS + 1);
    localparam int CODE_W      = 16;

    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_COMMIT  = 2'd2;

    localparam logic [7:0] CLS_MODIFIER = 8'hE0;
    localparam logic [7:0] CLS_MEDIA    = 8'hE2;
    localparam logic [7:0] CLS_MEDIA_LO = 8'hE4;
    localparam logic [7:0] CLS_MEDIA_HI = 8'hE7;
    localparam logic [7:0] CLS_KEY      = 8'hF0;

    typedef struct packed {
        logic [1:0]        operation;
        logic [CODE_W-1:0] key_code;
    } cmd_t;

    typedef struct packed {
        logic [7:0]        modifier_bits;
        logic [7:0]        key_slot_0;
        logic [7:0]        key_slot_1;
        logic [7:0]        key_slot_2;
        logic [7:0]        key_slot_3;
        logic [7:0]        key_slot_4;
        logic [7:0]        key_slot_5;
        logic [CODE_W-1:0] media_code;
        logic              bad_code_seen;
    } report_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_WB,
        ST_EMIT
    } state_t;

endpackage

### rtl/hkrb_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
module hkrb_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 4,
    parameter int DEPTH  = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/hkrb_report.sv
// Report accumulator: folds held key codes, in list order, into one report.
module hkrb_report (
    input  logic                         clk,
    input  logic                         clear,
    input  logic                         feed,
    input  logic [hkrb_pkg::CODE_W-1:0]  code,
    output hkrb_pkg::report_t            report
);

    logic [7:0]                      mods_reg;
    logic [7:0]                      mods_next;
    logic [7:0]                      slots_reg [hkrb_pkg::KEY_SLOTS];
    logic [7:0]                      slots_next [hkrb_pkg::KEY_SLOTS];
    logic [hkrb_pkg::SLOT_W-1:0]     used_reg;
    logic [hkrb_pkg::SLOT_W-1:0]     used_next;
    logic [hkrb_pkg::CODE_W-1:0]     media_reg;
    logic [hkrb_pkg::CODE_W-1:0]     media_next;
    logic                            bad_reg;
    logic                            bad_next;
    logic [7:0]                      cls;
    logic [7:0]                      low;

    assign cls = code[15:8];
    assign low = code[7:0];

    always_comb
    begin
        mods_next  = mods_reg;
        used_next  = used_reg;
        media_next = media_reg;
        bad_next   = bad_reg;
        for (int k = 0; k < hkrb_pkg::KEY_SLOTS; k++)
        begin
            slots_next[k] = slots_reg[k];
        end
        if (clear)
        begin
            mods_next  = '0;
            used_next  = '0;
            media_next = '0;
            bad_next   = 1'b0;
            for (int k = 0; k < hkrb_pkg::KEY_SLOTS; k++)
            begin
                slots_next[k] = '0;
            end
        end
        else if (feed)
        begin
            if (cls == hkrb_pkg::CLS_MODIFIER)
            begin
                mods_next = mods_reg | low;
            end
            else if (cls == hkrb_pkg::CLS_MEDIA ||
                     (cls >= hkrb_pkg::CLS_MEDIA_LO && cls <= hkrb_pkg::CLS_MEDIA_HI))
            begin
                media_next = code;
            end
            else if (cls == hkrb_pkg::CLS_KEY)
            begin
                // Codes beyond the sixth normal key are left out.
                if (used_reg < hkrb_pkg::SLOT_W'(hkrb_pkg::KEY_SLOTS))
                begin
                    for (int k = 0; k < hkrb_pkg::KEY_SLOTS; k++)
                    begin
                        if (used_reg == hkrb_pkg::SLOT_W'(k))
                        begin
                            slots_next[k] = low;
                        end
                    end
                    used_next = used_reg + 1'b1;
                end
            end
            else
            begin
                bad_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mods_reg  <= mods_next;
        used_reg  <= used_next;
        media_reg <= media_next;
        bad_reg   <= bad_next;
        for (int k = 0; k < hkrb_pkg::KEY_SLOTS; k++)
        begin
            slots_reg[k] <= slots_next[k];
        end
    end

    always_comb
    begin
        report.modifier_bits = mods_reg;
        report.key_slot_0    = slots_reg[0];
        report.key_slot_1    = slots_reg[1];
        report.key_slot_2    = slots_reg[2];
        report.key_slot_3    = slots_reg[3];
        report.key_slot_4    = slots_reg[4];
        report.key_slot_5    = slots_reg[5];
        report.media_code    = media_reg;
        report.bad_code_seen = bad_reg;
    end

endmodule

### rtl/hid_key_report_builder.sv
// Top level of the HID key report builder: request port, list control and report output.
//
// The block keeps the held key codes as an ordered list in a small synchronous RAM and
// builds a boot keyboard report from it on demand. A press is taken while the block is
// idle: its code is written at the end of the list unless the list already holds
// TRACK_DEPTH-2 entries. A release reads the list one entry per cycle through the RAM's
// read port until it finds the first matching code; it then reads the last entry and
// writes it over the match, and no request is taken until it is done. A commit
// while the report is dirty reads all held entries in order, one per cycle, into the
// report accumulator before the report is presented; the report then sits in an output
// register until it is taken, and the next request is accepted meanwhile. A further
// commit that finishes while the previous report is still waiting holds until the
// output register is free. The list RAM needs no clearing after reset, because only
// entries below the held count are ever read. Zero codes, the unused operation code and
// commits while clean are accepted and change nothing.
module hid_key_report_builder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  hkrb_pkg::cmd_t    cmd,
    output logic              report_valid,
    input  logic              report_stall,
    output hkrb_pkg::report_t report
);

    hkrb_pkg::state_t               state_reg;
    hkrb_pkg::state_t               state_next;
    logic [hkrb_pkg::IDX_W-1:0]     count_reg;
    logic [hkrb_pkg::IDX_W-1:0]     count_next;
    logic [hkrb_pkg::IDX_W-1:0]     rd_idx_reg;
    logic [hkrb_pkg::IDX_W-1:0]     rd_idx_next;
    logic                           rd_vld_reg;
    logic                           rd_vld_next;
    logic [hkrb_pkg::IDX_W-1:0]     rd_pos_reg;
    logic [hkrb_pkg::IDX_W-1:0]     match_pos_reg;
    logic [hkrb_pkg::IDX_W-1:0]     match_pos_next;
    logic                           dirty_reg;
    logic                           dirty_next;
    logic                           is_commit_reg;
    logic                           is_commit_next;
    logic [hkrb_pkg::CODE_W-1:0]    code_reg;
    logic [hkrb_pkg::CODE_W-1:0]    code_next;
    logic                           report_valid_reg;
    logic                           report_valid_next;
    hkrb_pkg::report_t              report_reg;

    logic                           accept;
    logic                           code_nonzero;
    logic                           issue;
    logic                           match;
    logic                           scan_done;
    logic                           out_free;
    logic                           load_report;

    logic                           ram_wr_en;
    logic [hkrb_pkg::IDX_W-1:0]     ram_wr_addr;
    logic [hkrb_pkg::CODE_W-1:0]    ram_wr_data;
    logic                           ram_rd_en;
    logic [hkrb_pkg::IDX_W-1:0]     ram_rd_addr;
    logic [hkrb_pkg::CODE_W-1:0]    ram_rd_data;

    logic                           acc_clear;
    logic                           acc_feed;
    hkrb_pkg::report_t              acc_report;

    hkrb_ram #(
        .DATA_W (hkrb_pkg::CODE_W),
        .ADDR_W (hkrb_pkg::IDX_W),
        .DEPTH  (hkrb_pkg::TRACK_DEPTH)
    ) u_list_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    hkrb_report u_report (
        .clk    (clk),
        .clear  (acc_clear),
        .feed   (acc_feed),
        .code   (ram_rd_data),
        .report (acc_report)
    );

    // Requests are only taken while the list controller is idle.
    assign accept       = cmd_valid && !cmd_stall;
    assign code_nonzero = (cmd.key_code != '0);

    // A scan keeps one read in flight; it is finished once every held entry has been
    // issued and the last read data has been looked at.
    assign issue     = (rd_idx_reg < count_reg);
    assign match     = rd_vld_reg && !is_commit_reg && (ram_rd_data == code_reg);
    assign scan_done = !issue && !rd_vld_reg;

    assign out_free    = !report_valid_reg || !report_stall;
    assign load_report = (state_reg == hkrb_pkg::ST_EMIT) && out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hkrb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.operation == hkrb_pkg::OP_COMMIT && dirty_reg)
                    begin
                        state_next = hkrb_pkg::ST_SCAN;
                    end
                    else if (cmd.operation == hkrb_pkg::OP_RELEASE && code_nonzero)
                    begin
                        state_next = hkrb_pkg::ST_SCAN;
                    end
                end
            end
            hkrb_pkg::ST_SCAN:
            begin
                if (match)
                begin
                    state_next = hkrb_pkg::ST_LAST;
                end
                else if (scan_done)
                begin
                    state_next = is_commit_reg ? hkrb_pkg::ST_EMIT : hkrb_pkg::ST_IDLE;
                end
            end
            hkrb_pkg::ST_LAST:
            begin
                state_next = hkrb_pkg::ST_WB;
            end
            hkrb_pkg::ST_WB:
            begin
                state_next = hkrb_pkg::ST_IDLE;
            end
            hkrb_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = hkrb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hkrb_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller: RAM ports, accumulator control and request stall.
    always_comb
    begin
        cmd_stall   = 1'b1;
        ram_wr_en   = 1'b0;
        ram_wr_addr = count_reg;
        ram_wr_data = cmd.key_code;
        ram_rd_en   = 1'b0;
        ram_rd_addr = rd_idx_reg;
        acc_clear   = 1'b0;
        acc_feed    = 1'b0;
        case (state_reg)
            hkrb_pkg::ST_IDLE:
            begin
                cmd_stall = 1'b0;
                // A press appends in the same cycle, unless the list is full.
                ram_wr_en = cmd_valid && cmd.operation == hkrb_pkg::OP_PRESS && code_nonzero
                            && (count_reg < hkrb_pkg::IDX_W'(hkrb_pkg::CAPACITY));
                acc_clear = cmd_valid && cmd.operation == hkrb_pkg::OP_COMMIT;
            end
            hkrb_pkg::ST_SCAN:
            begin
                ram_rd_en = issue;
                acc_feed  = rd_vld_reg && is_commit_reg;
            end
            hkrb_pkg::ST_LAST:
            begin
                // Fetch the last entry, which moves into the released slot.
                ram_rd_en   = 1'b1;
                ram_rd_addr = count_reg - 1'b1;
            end
            hkrb_pkg::ST_WB:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = match_pos_reg;
                ram_wr_data = ram_rd_data;
            end
            hkrb_pkg::ST_EMIT:
            begin
                cmd_stall = 1'b1;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    // Data path next values.
    always_comb
    begin
        count_next        = count_reg;
        dirty_next        = dirty_reg;
        is_commit_next    = is_commit_reg;
        code_next         = code_reg;
        rd_idx_next       = rd_idx_reg;
        match_pos_next    = match_pos_reg;
        rd_vld_next       = 1'b0;
        report_valid_next = report_valid_reg && report_stall;

        if (accept)
        begin
            rd_idx_next    = '0;
            is_commit_next = (cmd.operation == hkrb_pkg::OP_COMMIT);
            code_next      = cmd.key_code;
            if (cmd.operation == hkrb_pkg::OP_COMMIT)
            begin
                dirty_next = 1'b0;
            end
            else if ((cmd.operation == hkrb_pkg::OP_PRESS ||
                      cmd.operation == hkrb_pkg::OP_RELEASE) && code_nonzero)
            begin
                // Every press or release of a real code marks the report dirty, even a
                // press that is dropped or a release of a code that is not held.
                dirty_next = 1'b1;
            end
        end

        if (ram_wr_en && state_reg == hkrb_pkg::ST_IDLE)
        begin
            count_next = count_reg + 1'b1;
        end

        if (state_reg == hkrb_pkg::ST_SCAN)
        begin
            if (issue)
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
            end
            rd_vld_next = issue && (state_next == hkrb_pkg::ST_SCAN);
            if (match)
            begin
                match_pos_next = rd_pos_reg;
            end
        end

        if (state_reg == hkrb_pkg::ST_WB)
        begin
            count_next = count_reg - 1'b1;
        end

        if (load_report)
        begin
            report_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= hkrb_pkg::ST_IDLE;
            count_reg        <= '0;
            dirty_reg        <= 1'b0;
            rd_vld_reg       <= 1'b0;
            report_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            dirty_reg        <= dirty_next;
            rd_vld_reg       <= rd_vld_next;
            report_valid_reg <= report_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_commit_reg <= is_commit_next;
        code_reg      <= code_next;
        rd_idx_reg    <= rd_idx_next;
        rd_pos_reg    <= rd_idx_reg;
        match_pos_reg <= match_pos_next;
        if (load_report)
        begin
            report_reg <= acc_report;
        end
    end

    assign report_valid = report_valid_reg;
    assign report       = report_reg;

    // The list never grows past its capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hkrb_pkg::IDX_W'(hkrb_pkg::CAPACITY))
        else $error("held count beyond capacity");

    // The list RAM is never read and written in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr_en && ram_rd_en))
        else $error("list RAM read and write overlap");

    // A new report only appears after the emit state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(report_valid_reg) |-> $past(state_reg == hkrb_pkg::ST_EMIT))
        else $error("report presented without a finished scan");

    // A release of a real code always starts a list scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.operation == hkrb_pkg::OP_RELEASE && code_nonzero)
        |=> (state_reg == hkrb_pkg::ST_SCAN))
        else $error("release did not start a scan");

    // A write-back always shrinks the list by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hkrb_pkg::ST_WB) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("release write-back did not shrink the list");

endmodule

### dv/tb.sv
// Self-checking testbench for the HID key report builder: directed and random requests.
`timescale 1ns / 100ps

module tb;

    // The package names no code for the spare operation value, so it is named here.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // A release can still be scanning the list after the last report has gone, so the quiet
    // time after each phase must cover a full release with some margin.
    localparam int DRAIN_CYCLES = 2 * hkrb_pkg::TRACK_DEPTH;

    // The slowest correct gap between two handshakes is a long sender gap, a full list scan
    // and a report waiting out a long receiver stall.
    localparam int WATCHDOG_LIMIT = 2000;

    logic              clk;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_stall;
    hkrb_pkg::cmd_t    cmd;
    logic              report_valid;
    logic              report_stall = 1'b0;
    hkrb_pkg::report_t report;

    // Pacing of both sides, in percent per cycle.
    int send_gap_pct = 0;
    int stall_pct    = 0;

    // Our own picture of the block: the held list, its length and the dirty flag.
    logic [hkrb_pkg::CODE_W-1:0] held_codes [hkrb_pkg::TRACK_DEPTH];
    int                          held_total   = 0;
    bit                          report_dirty = 1'b0;
    hkrb_pkg::report_t           expected_reports [$];

    int error_count     = 0;
    int reports_checked = 0;
    int presses_seen    = 0;
    int releases_seen   = 0;
    int commits_seen    = 0;
    int ignored_seen    = 0;
    int quiet_cycles    = 0;

    hid_key_report_builder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    // Updates the held list exactly as the block should for one accepted request, and
    // queues the report that a commit of a dirty list must produce.
    task automatic predict_request(input hkrb_pkg::cmd_t r);
        hkrb_pkg::report_t rep;
        logic [7:0]        slot_bytes [hkrb_pkg::KEY_SLOTS];
        logic [7:0]        cls;
        int                filled;
        int                pos;
        rep    = '0;
        filled = 0;
        pos    = -1;
        if (r.operation == hkrb_pkg::OP_COMMIT)
        begin
            commits_seen++;
            if (report_dirty)
            begin
                foreach (slot_bytes[s])
                    slot_bytes[s] = 8'h00;
                // Walk the list in order: modifiers are ORed together, the last media code
                // wins, the first six ordinary keys fill the slots, and any other class
                // marks the report as carrying a bad code.
                for (int i = 0; i < held_total; i++)
                begin
                    cls = held_codes[i][15:8];
                    if (cls == hkrb_pkg::CLS_MODIFIER)
                        rep.modifier_bits |= held_codes[i][7:0];
                    else if (cls == hkrb_pkg::CLS_MEDIA ||
                             (cls >= hkrb_pkg::CLS_MEDIA_LO && cls <= hkrb_pkg::CLS_MEDIA_HI))
                        rep.media_code = held_codes[i];
                    else if (cls == hkrb_pkg::CLS_KEY)
                    begin
                        if (filled < hkrb_pkg::KEY_SLOTS)
                        begin
                            slot_bytes[filled] = held_codes[i][7:0];
                            filled++;
                        end
                    end
                    else
                        rep.bad_code_seen = 1'b1;
                end
                rep.key_slot_0 = slot_bytes[0];
                rep.key_slot_1 = slot_bytes[1];
                rep.key_slot_2 = slot_bytes[2];
                rep.key_slot_3 = slot_bytes[3];
                rep.key_slot_4 = slot_bytes[4];
                rep.key_slot_5 = slot_bytes[5];
                expected_reports.push_back(rep);
                report_dirty = 1'b0;
            end
        end
        else if (r.operation == OP_UNUSED || r.key_code == '0)
            ignored_seen++;
        else
        begin
            // Every press or release of a real code dirties the report, even when the
            // list itself does not change.
            report_dirty = 1'b1;
            if (r.operation == hkrb_pkg::OP_PRESS)
            begin
                presses_seen++;
                if (held_total < hkrb_pkg::CAPACITY)
                begin
                    held_codes[held_total] = r.key_code;
                    held_total++;
                end
            end
            else
            begin
                releases_seen++;
                for (int i = 0; i < held_total; i++)
                begin
                    if (held_codes[i] == r.key_code)
                    begin
                        pos = i;
                        break;
                    end
                end
                // The first match is overwritten by the last entry, so order is not kept.
                if (pos >= 0)
                begin
                    held_codes[pos] = held_codes[held_total - 1];
                    held_total--;
                end
            end
        end
    endtask

    // Offers one request, with random gaps in front of it, and returns just after the edge
    // at which it is taken. Valid is left high so that a following request can go straight
    // on; whoever stops sending lowers it.
    task automatic send_request(input logic [1:0] op,
                                input logic [hkrb_pkg::CODE_W-1:0] code);
        hkrb_pkg::cmd_t r;
        r.operation = op;
        r.key_code  = code;
        while ($urandom_range(99) < send_gap_pct)
        begin
            cmd_valid <= 1'b0;
            cmd       <= hkrb_pkg::cmd_t'($urandom);
            @(posedge clk);
        end
        cmd       <= r;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        predict_request(r);
    endtask

    // Stops sending, waits for every outstanding report and then lets any release that is
    // still scanning the list run to its end.
    task automatic wait_for_drain();
        cmd_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Draws a code that is mostly of a known class, sometimes of a class just beside one,
    // and sometimes wholly random.
    function automatic logic [hkrb_pkg::CODE_W-1:0] pick_key_code();
        logic [7:0] cls;
        case ($urandom_range(7))
            0:       cls = hkrb_pkg::CLS_MODIFIER;
            1:       cls = hkrb_pkg::CLS_MEDIA;
            2:       cls = 8'($urandom_range(hkrb_pkg::CLS_MEDIA_HI, hkrb_pkg::CLS_MEDIA_LO));
            3, 4:    cls = hkrb_pkg::CLS_KEY;
            5:
            begin
                case ($urandom_range(3))
                    0:       cls = hkrb_pkg::CLS_MEDIA - 8'd1;
                    1:       cls = hkrb_pkg::CLS_MEDIA + 8'd1;
                    2:       cls = hkrb_pkg::CLS_MEDIA_HI + 8'd1;
                    default: cls = hkrb_pkg::CLS_KEY + 8'd1;
                endcase
            end
            default: cls = 8'($urandom);
        endcase
        return {cls, 8'($urandom)};
    endfunction

    // Requests that must leave no trace: a commit while clean, zero codes on press and
    // release, and the spare operation code carrying an all-ones code.
    task automatic test_ignored_requests();
        send_request(hkrb_pkg::OP_COMMIT, 16'hFFFF);
        send_request(hkrb_pkg::OP_PRESS, 16'h0000);
        send_request(hkrb_pkg::OP_RELEASE, 16'h0000);
        send_request(OP_UNUSED, 16'hFFFF);
        send_request(hkrb_pkg::OP_COMMIT, 16'h0000);
        wait_for_drain();
    endtask

    // Fills the list with every class: two modifiers to OR, three media codes where the
    // last must win, seven ordinary keys of which only six fit the report, and two codes
    // of unknown class. One more press with the list full must be dropped.
    task automatic test_report_fields();
        send_request(hkrb_pkg::OP_PRESS, 16'hF004);
        send_request(hkrb_pkg::OP_PRESS, 16'hE002);
        send_request(hkrb_pkg::OP_PRESS, 16'hE020);
        send_request(hkrb_pkg::OP_PRESS, 16'hE2CD);
        send_request(hkrb_pkg::OP_PRESS, 16'hE701);
        send_request(hkrb_pkg::OP_PRESS, 16'hF0FF);
        send_request(hkrb_pkg::OP_PRESS, 16'hE301);
        send_request(hkrb_pkg::OP_PRESS, 16'hF005);
        send_request(hkrb_pkg::OP_PRESS, 16'hF006);
        send_request(hkrb_pkg::OP_PRESS, 16'hF007);
        send_request(hkrb_pkg::OP_PRESS, 16'hF008);
        send_request(hkrb_pkg::OP_PRESS, 16'hF009);
        send_request(hkrb_pkg::OP_PRESS, 16'hE4AA);
        send_request(hkrb_pkg::OP_PRESS, 16'hFFFF);
        send_request(hkrb_pkg::OP_PRESS, 16'hE0FF);
        send_request(hkrb_pkg::OP_COMMIT, 16'hFFFF);
        wait_for_drain();
    endtask

    // A release moves the last entry into the gap; a release of a code not held still
    // dirties the report; with a duplicate held only the first copy goes.
    task automatic test_release_order();
        send_request(hkrb_pkg::OP_RELEASE, 16'hF004);
        send_request(hkrb_pkg::OP_RELEASE, 16'h0001);
        send_request(hkrb_pkg::OP_COMMIT, 16'h0000);
        send_request(hkrb_pkg::OP_RELEASE, 16'hE2CD);
        send_request(hkrb_pkg::OP_PRESS, 16'hF0FF);
        send_request(hkrb_pkg::OP_RELEASE, 16'hF0FF);
        send_request(hkrb_pkg::OP_COMMIT, 16'h5A5A);
        wait_for_drain();
    endtask

    // Mostly realistic typing: presses of plausible codes, releases of codes actually
    // held, and frequent commits; the remaining tenth is noise of any operation and code.
    task automatic test_random_traffic(input int count, input int gap_pct, input int hold_pct);
        int         dice;
        logic [1:0] op;
        logic [15:0] code;
        send_gap_pct = gap_pct;
        stall_pct    = hold_pct;
        repeat (count)
        begin
            dice = $urandom_range(99);
            if (dice < 35)
            begin
                op   = hkrb_pkg::OP_PRESS;
                code = pick_key_code();
            end
            else if (dice < 65)
            begin
                op = hkrb_pkg::OP_RELEASE;
                if (held_total > 0 && $urandom_range(9) != 0)
                    code = held_codes[$urandom_range(held_total - 1)];
                else
                    code = pick_key_code();
            end
            else if (dice < 90)
            begin
                op   = hkrb_pkg::OP_COMMIT;
                code = 16'($urandom);
            end
            else
            begin
                op   = 2'($urandom_range(3));
                code = $urandom_range(1) ? 16'h0000 : 16'($urandom);
            end
            send_request(op, code);
        end
        wait_for_drain();
    endtask

    // Receiver: takes each report at an edge where it is valid and not stalled, compares
    // it with the oldest expected one, then decides the stall for the next cycle.
    always @(posedge clk)
    begin : report_monitor
        hkrb_pkg::report_t want;
        if (rst_n && report_valid === 1'b1 && !report_stall)
        begin
            if (expected_reports.size() == 0)
                flag_error("report presented with none outstanding");
            else
            begin
                want = expected_reports.pop_front();
                check_field("modifier_bits", 16'(report.modifier_bits),
                            16'(want.modifier_bits));
                check_field("key_slot_0", 16'(report.key_slot_0), 16'(want.key_slot_0));
                check_field("key_slot_1", 16'(report.key_slot_1), 16'(want.key_slot_1));
                check_field("key_slot_2", 16'(report.key_slot_2), 16'(want.key_slot_2));
                check_field("key_slot_3", 16'(report.key_slot_3), 16'(want.key_slot_3));
                check_field("key_slot_4", 16'(report.key_slot_4), 16'(want.key_slot_4));
                check_field("key_slot_5", 16'(report.key_slot_5), 16'(want.key_slot_5));
                check_field("media_code", report.media_code, want.media_code);
                check_field("bad_code_seen", 16'(report.bad_code_seen),
                            16'(want.bad_code_seen));
                reports_checked++;
            end
        end
        report_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: any handshake on either side resets the count of quiet cycles.
    always @(posedge clk)
    begin
        if ((cmd_valid === 1'b1 && cmd_stall === 1'b0) ||
            (report_valid === 1'b1 && !report_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d reports outstanding", expected_reports.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        foreach (held_codes[i])
            held_codes[i] = '0;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_requests();
        test_report_fields();
        test_release_order();

        // Four pacing phases: free flow, a slow sender, a slow receiver, and both at once.
        test_random_traffic(120, 0, 0);
        test_random_traffic(110, 64, 0);
        test_random_traffic(110, 0, 64);
        test_random_traffic(110, 26, 26);

        $display("Run covered %0d presses, %0d releases, %0d commits and %0d ignored requests",
                 presses_seen, releases_seen, commits_seen, ignored_seen);
        $display("under four pacing phases; %0d reports compared, %0d mismatches.",
                 reports_checked, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
